>>> hw/rtl/hsl2rgb_pkg.sv
// Shared constants and types for the HSL to RGB converter pipeline.
package hsl2rgb_pkg;

    localparam int DEF_OUT_BITS = 16;
    localparam int FIELD_W      = 16;
    localparam int HUE_W        = 9;
    localparam int PCT_W        = 7;
    localparam int PQ_W         = 14;
    localparam int WEIGHT_W     = 6;
    localparam int UNIT_W       = 20;
    localparam int CH_N         = 4;
    localparam int NSTAGE       = 5;

    localparam int HUE_MAX     = 360;
    localparam int PCT_MAX     = 100;
    localparam int PCT_HALF    = 50;
    localparam int RAMP_STEP   = 60;
    localparam int UNIT_DEN    = 600000;
    localparam int UNIT_HALF   = UNIT_DEN / 2;
    localparam int ALPHA_SCALE = UNIT_DEN / PCT_MAX;

    // Lane order inside the channel vectors.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    typedef struct packed {
        logic                err;
        logic [PQ_W-1:0]     p;
        logic [PQ_W-1:0]     d;
        logic [WEIGHT_W-1:0] w_red;
        logic [WEIGHT_W-1:0] w_green;
        logic [WEIGHT_W-1:0] w_blue;
        logic [PCT_W-1:0]    alpha;
    } pq_t;

endpackage

>>> hw/rtl/hsl2rgb_pq.sv
// Stage 1: range check, p and q levels, and hue ramp weights per channel.
module hsl2rgb_pq (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [hsl2rgb_pkg::HUE_W-1:0] hue_degrees,
    input  logic [hsl2rgb_pkg::PCT_W-1:0] saturation_pct,
    input  logic [hsl2rgb_pkg::PCT_W-1:0] lightness_pct,
    input  logic [hsl2rgb_pkg::PCT_W-1:0] alpha_pct,
    output hsl2rgb_pkg::pq_t          pq_out
);
    import hsl2rgb_pkg::*;

    localparam int MW = 2 * PCT_W + 1;

    // Weight of (q - p) for an angle in 0..360.
    function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic [HUE_W-1:0] ang);
        logic [HUE_W-1:0] fall;
        fall = HUE_W'(4 * RAMP_STEP) - ang;
        if (ang < HUE_W'(RAMP_STEP))
            return ang[WEIGHT_W-1:0];
        else if (ang < HUE_W'(3 * RAMP_STEP))
            return WEIGHT_W'(RAMP_STEP);
        else if (ang < HUE_W'(4 * RAMP_STEP))
            return fall[WEIGHT_W-1:0];
        else
            return '0;
    endfunction

    pq_t pq_reg, pq_next;

    logic               err;
    logic               l_low;
    logic [PCT_W-1:0]   mul_a;
    logic [PCT_W:0]     mul_b;
    logic [MW-1:0]      mprod;
    logic [MW-1:0]      q_val;
    logic [MW-1:0]      p_val;
    logic [MW-1:0]      d_val;
    logic [HUE_W-1:0]   ang_red;
    logic [HUE_W-1:0]   ang_blue;

    always_comb begin
        err = (hue_degrees > HUE_W'(HUE_MAX)) || (saturation_pct > PCT_W'(PCT_MAX)) ||
              (lightness_pct > PCT_W'(PCT_MAX)) || (alpha_pct > PCT_W'(PCT_MAX));
        l_low = lightness_pct < PCT_W'(PCT_HALF);
        // q = L*(100+S) below half lightness, else 100*L + S*(100-L)
        mul_a = l_low ? lightness_pct : saturation_pct;
        mul_b = l_low ? ((PCT_W+1)'(PCT_MAX) + {1'b0, saturation_pct})
                      : ((PCT_W+1)'(PCT_MAX) - {1'b0, lightness_pct});
        mprod = MW'(mul_a) * MW'(mul_b);
        q_val = l_low ? mprod : (MW'(lightness_pct) * MW'(PCT_MAX) + mprod);
        p_val = MW'(lightness_pct) * MW'(2 * PCT_MAX) - q_val;
        d_val = q_val - p_val;

        // wrap hue + 120 and hue - 120 into 0..360
        ang_red  = (hue_degrees > HUE_W'(HUE_MAX - 2 * RAMP_STEP))
                   ? hue_degrees - HUE_W'(HUE_MAX - 2 * RAMP_STEP)
                   : hue_degrees + HUE_W'(2 * RAMP_STEP);
        ang_blue = (hue_degrees >= HUE_W'(2 * RAMP_STEP))
                   ? hue_degrees - HUE_W'(2 * RAMP_STEP)
                   : hue_degrees + HUE_W'(HUE_MAX - 2 * RAMP_STEP);

        pq_next.err     = err;
        pq_next.p       = err ? '0 : p_val[PQ_W-1:0];
        pq_next.d       = err ? '0 : d_val[PQ_W-1:0];
        pq_next.w_red   = ramp_weight(ang_red);
        pq_next.w_green = ramp_weight(hue_degrees);
        pq_next.w_blue  = ramp_weight(ang_blue);
        pq_next.alpha   = err ? '0 : alpha_pct;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pq_reg <= pq_next;
        end
    end

    assign pq_out = pq_reg;

endmodule

>>> hw/rtl/hsl2rgb_ramp.sv
// Stage 2: channel levels in units of 1/600000 from p, q - p and the ramp weights.
module hsl2rgb_ramp (
    input  logic                 aclk,
    input  logic                 en,
    input  hsl2rgb_pkg::pq_t     pq_in,
    output logic [hsl2rgb_pkg::CH_N-1:0][hsl2rgb_pkg::UNIT_W-1:0] level,
    output logic                 err
);
    import hsl2rgb_pkg::*;

    logic [CH_N-1:0][UNIT_W-1:0] level_reg, level_next;
    logic                        err_reg;
    logic [UNIT_W-1:0]           base;

    always_comb begin
        base = UNIT_W'(pq_in.p) * UNIT_W'(RAMP_STEP);
        level_next[CH_RED]   = base + UNIT_W'(pq_in.d) * UNIT_W'(pq_in.w_red);
        level_next[CH_GREEN] = base + UNIT_W'(pq_in.d) * UNIT_W'(pq_in.w_green);
        level_next[CH_BLUE]  = base + UNIT_W'(pq_in.d) * UNIT_W'(pq_in.w_blue);
        level_next[CH_ALPHA] = UNIT_W'(pq_in.alpha) * UNIT_W'(ALPHA_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            level_reg <= level_next;
            err_reg   <= pq_in.err;
        end
    end

    assign level = level_reg;
    assign err   = err_reg;

endmodule

>>> hw/rtl/hsl2rgb_scale.sv
// Stages 3 to 5 of one lane: round(level * full_scale / 600000) by reciprocal multiply.
module hsl2rgb_scale #(
    parameter int OUT_BITS = hsl2rgb_pkg::DEF_OUT_BITS
) (
    input  logic                            aclk,
    input  hsl2rgb_pkg::stage_en_t          en,
    input  logic [hsl2rgb_pkg::UNIT_W-1:0]  level,
    output logic [hsl2rgb_pkg::FIELD_W-1:0] frac
);
    import hsl2rgb_pkg::*;

    localparam int XW    = UNIT_W + OUT_BITS;   // numerator width
    localparam int HW    = 28;                  // high slice used for the estimate
    localparam int CUT   = XW - HW;
    localparam int SH    = CUT + 30;
    localparam int RW    = SH - 19;
    localparam int QW    = OUT_BITS + 1;
    localparam int REM_W = 21;                  // remainder stays below twice the divisor
    localparam logic [OUT_BITS-1:0] FULL = {OUT_BITS{1'b1}};
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / 64'(UNIT_DEN));

    logic [XW-1:0]       x_reg, x_next;
    logic [QW-1:0]       qe_reg, qe_next;
    logic [REM_W-1:0]    xl_reg;
    logic [FIELD_W-1:0]  frac_reg, frac_next;
    logic [HW+RW-1:0]    est_prod;
    logic [QW+UNIT_W-1:0] back_prod;
    logic [REM_W-1:0]    rem;
    logic [QW-1:0]       quot;
    logic [QW+FIELD_W-1:0] quot_ext;

    always_comb begin
        x_next    = XW'(level) * XW'(FULL) + XW'(UNIT_HALF);
        est_prod  = (HW+RW)'(x_reg[XW-1:CUT]) * (HW+RW)'(RECIP);
        qe_next   = est_prod[HW+RW-1:30];
        // estimate is low by at most one; fix up with the remainder
        back_prod = (QW+UNIT_W)'(qe_reg) * (QW+UNIT_W)'(UNIT_DEN);
        rem       = xl_reg - back_prod[REM_W-1:0];
        quot      = qe_reg + QW'(rem >= REM_W'(UNIT_DEN));
        quot_ext  = (QW+FIELD_W)'(quot);
        frac_next = quot_ext[FIELD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            x_reg <= x_next;
        end
        if (en.s4) begin
            qe_reg <= qe_next;
            xl_reg <= x_reg[REM_W-1:0];
        end
        if (en.s5) begin
            frac_reg <= frac_next;
        end
    end

    assign frac = frac_reg;

endmodule

>>> hw/rtl/hsl_to_rgb_converter_core.sv
// HSL to RGB converter: takes one color per transfer (hue 0..360 degrees, saturation,
// lightness and opacity 0..100 percent) and returns red, green, blue and opacity as
// fractions of OUT_BITS bits, rounded to nearest and masked to 16-bit fields. Any input
// out of range sets the tuser flag and zeroes all four fractions. The pipeline has five
// register stages and takes one transfer per cycle, and a stall on the output holds the
// pipe while empty stages still fill. The stage count follows from the ramp multiply and
// the three-step reciprocal divide by 600000 in each output lane.
module hsl_to_rgb_converter_core #(
    parameter int OUT_BITS = hsl2rgb_pkg::DEF_OUT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue_degrees, saturation_pct, lightness_pct, alpha_pct
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // red_frac, green_frac, blue_frac, alpha_frac
    output logic        m_tuser    // range_error
);
    import hsl2rgb_pkg::*;

    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE-1:0] en;
    logic [2:0]        err_reg;
    stage_en_t         lane_en;
    pq_t               pq;
    logic [CH_N-1:0][UNIT_W-1:0] level;
    logic              level_err;
    logic [CH_N-1:0][FIELD_W-1:0] frac;

    // a stage advances when empty or when the next one advances
    always_comb begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
        lane_en.s3 = en[2];
        lane_en.s4 = en[3];
        lane_en.s5 = en[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            err_reg[0] <= level_err;
        end
        if (en[3]) begin
            err_reg[1] <= err_reg[0];
        end
        if (en[4]) begin
            err_reg[2] <= err_reg[1];
        end
    end

    hsl2rgb_pq u_pq (
        .aclk           (aclk),
        .en             (en[0]),
        .hue_degrees    (s_tdata[8:0]),
        .saturation_pct (s_tdata[15:9]),
        .lightness_pct  (s_tdata[22:16]),
        .alpha_pct      (s_tdata[29:23]),
        .pq_out         (pq)
    );

    hsl2rgb_ramp u_ramp (
        .aclk  (aclk),
        .en    (en[1]),
        .pq_in (pq),
        .level (level),
        .err   (level_err)
    );

    for (genvar c = 0; c < CH_N; c++) begin : g_lane
        hsl2rgb_scale #(
            .OUT_BITS (OUT_BITS)
        ) u_scale (
            .aclk  (aclk),
            .en    (lane_en),
            .level (level[c]),
            .frac  (frac[c])
        );
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = frac;
    assign m_tuser  = err_reg[2];

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("range error result carries nonzero color");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg == '1))
        else $error("input stalled while a pipeline stage is empty");

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("accepted transfer lost or duplicated in pipeline");
`endif

endmodule

>>> tb/sv/hsl_to_rgb_converter_core_tb.sv
// Self-checking testbench for the HSL to RGB converter core.
`timescale 1ns / 100ps

module hsl_to_rgb_converter_core_tb;

    import hsl2rgb_pkg::*;

    localparam int OUT_BITS    = DEF_OUT_BITS;
    localparam int RAND_ITEMS  = 750;
    localparam int TAIL_CYCLES = 4 * NSTAGE;
    localparam int MAX_PRINTS  = 60;

    typedef struct {
        logic [HUE_W-1:0]   hue;
        logic [PCT_W-1:0]   sat;
        logic [PCT_W-1:0]   light;
        logic [PCT_W-1:0]   alpha;
        logic [FIELD_W-1:0] red_frac;
        logic [FIELD_W-1:0] green_frac;
        logic [FIELD_W-1:0] blue_frac;
        logic [FIELD_W-1:0] alpha_frac;
        logic               range_error;
    } color_expect_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    color_expect_t color_expect_q[$];
    int            mismatch_cnt = 0;
    bit            idle_on      = 1'b0;
    int            stall_left   = 0;

    hsl_to_rgb_converter_core #(
        .OUT_BITS(OUT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hue ramp in units of 1/600000; p and q are in units of 1/10000.
    function automatic longint hue_ramp(longint p, longint q, int ang);
        if (ang < 0) ang += HUE_MAX;
        if (ang > HUE_MAX) ang -= HUE_MAX;
        if (ang < RAMP_STEP) return p * RAMP_STEP + (q - p) * ang;
        if (ang < 3 * RAMP_STEP) return q * RAMP_STEP;
        if (ang < 4 * RAMP_STEP) return p * RAMP_STEP + (q - p) * (4 * RAMP_STEP - ang);
        return p * RAMP_STEP;
    endfunction

    function automatic logic [FIELD_W-1:0] unit_to_frac(longint v);
        longint full_scale;
        full_scale = (longint'(1) << OUT_BITS) - 1;
        if (v < 0) v = 0;
        if (v > UNIT_DEN) v = UNIT_DEN;
        return FIELD_W'((v * full_scale + UNIT_HALF) / UNIT_DEN);
    endfunction

    function automatic color_expect_t hsl_to_rgb_predict(logic [HUE_W-1:0] hue,
                                                         logic [PCT_W-1:0] sat,
                                                         logic [PCT_W-1:0] light,
                                                         logic [PCT_W-1:0] alpha);
        color_expect_t e;
        longint        q;
        longint        p;
        longint        hi;
        longint        si;
        longint        li;
        longint        full_scale;
        full_scale    = (longint'(1) << OUT_BITS) - 1;
        e.hue         = hue;
        e.sat         = sat;
        e.light       = light;
        e.alpha       = alpha;
        e.red_frac    = '0;
        e.green_frac  = '0;
        e.blue_frac   = '0;
        e.alpha_frac  = '0;
        e.range_error = 1'b0;
        if (hue > HUE_MAX || sat > PCT_MAX || light > PCT_MAX || alpha > PCT_MAX) begin
            e.range_error = 1'b1;
            return e;
        end
        hi = longint'(hue);
        si = longint'(sat);
        li = longint'(light);
        if (li < PCT_HALF) begin
            q = li * (PCT_MAX + si);
        end else begin
            q = PCT_MAX * li + PCT_MAX * si - li * si;
        end
        p = 2 * PCT_MAX * li - q;
        e.red_frac   = unit_to_frac(hue_ramp(p, q, int'(hi) + 120));
        e.green_frac = unit_to_frac(hue_ramp(p, q, int'(hi)));
        e.blue_frac  = unit_to_frac(hue_ramp(p, q, int'(hi) - 120));
        e.alpha_frac = FIELD_W'((longint'(alpha) * full_scale + PCT_HALF) / PCT_MAX);
        return e;
    endfunction

    task automatic report_mismatch(string field, color_expect_t e, longint got, longint exp);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("%0t: %s got %0d exp %0d (h=%0d s=%0d l=%0d a=%0d)", $realtime,
                     field, got, exp, e.hue, e.sat, e.light, e.alpha);
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Predict at input transfer, then check any output transfer on the same edge.
    always @(posedge aclk) begin
        color_expect_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                color_expect_q.push_back(hsl_to_rgb_predict(s_tdata[8:0], s_tdata[15:9],
                                                            s_tdata[22:16], s_tdata[29:23]));
            if (m_tvalid && m_tready) begin
                if (color_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_PRINTS)
                        $display("%0t: output transfer with nothing pending", $realtime);
                end else begin
                    e = color_expect_q.pop_front();
                    if (m_tdata[15:0] !== e.red_frac)
                        report_mismatch("red_frac", e, longint'(m_tdata[15:0]),
                                        longint'(e.red_frac));
                    if (m_tdata[31:16] !== e.green_frac)
                        report_mismatch("green_frac", e, longint'(m_tdata[31:16]),
                                        longint'(e.green_frac));
                    if (m_tdata[47:32] !== e.blue_frac)
                        report_mismatch("blue_frac", e, longint'(m_tdata[47:32]),
                                        longint'(e.blue_frac));
                    if (m_tdata[63:48] !== e.alpha_frac)
                        report_mismatch("alpha_frac", e, longint'(m_tdata[63:48]),
                                        longint'(e.alpha_frac));
                    if (m_tuser !== e.range_error)
                        report_mismatch("range_error", e, longint'(m_tuser),
                                        longint'(e.range_error));
                end
            end
        end
    end

    // Output back-pressure: mostly short stalls, a few long ones.
    always @(posedge aclk) begin
        int r;
        if (!idle_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                stall_left = (r < 3) ? $urandom_range(8, 40) : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                              logic [PCT_W-1:0] light, logic [PCT_W-1:0] alpha);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, alpha, light, sat, hue};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic test_extremes();
        send_color(0, 0, 0, 0);
        send_color(360, 100, 100, 100);
        send_color(0, 100, 50, 100);
        send_color(120, 100, 50, 50);
        send_color(240, 100, 49, 1);
        send_color(200, 0, 37, 99);
        send_color(300, 73, 100, 64);
    endtask

    // Hue wrap and ramp edges, seen through all three sample angles.
    task automatic test_ramp_edges();
        send_color(59, 80, 30, 50);
        send_color(60, 80, 70, 50);
        send_color(179, 55, 50, 50);
        send_color(180, 55, 51, 50);
        send_color(239, 90, 20, 50);
        send_color(241, 90, 80, 50);
        send_color(359, 100, 45, 50);
        send_color(1, 100, 55, 50);
    endtask

    task automatic test_out_of_range();
        send_color(361, 50, 50, 50);
        send_color(511, 0, 0, 0);
        send_color(10, 101, 50, 50);
        send_color(10, 50, 127, 50);
        send_color(10, 50, 50, 101);
        send_color(511, 127, 127, 127);
    endtask

    task automatic test_random();
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic [PCT_W-1:0] alpha;
        int               r;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            // First stretch runs back to back, the rest with gaps on both sides.
            idle_on = (i >= 150);
            r = $urandom_range(0, 99);
            if (r < 85) begin
                hue   = (r < 15)
                        ? HUE_W'(RAMP_STEP * $urandom_range(0, 6) + $urandom_range(0, 2) - 1)
                        : HUE_W'($urandom_range(0, HUE_MAX));
                if (hue > HUE_MAX) hue = HUE_W'(HUE_MAX);
                sat   = (r < 25) ? PCT_W'(PCT_MAX * $urandom_range(0, 1))
                                 : PCT_W'($urandom_range(0, PCT_MAX));
                light = PCT_W'($urandom_range(0, PCT_MAX));
                alpha = PCT_W'($urandom_range(0, PCT_MAX));
            end else begin
                hue   = HUE_W'($urandom);
                sat   = PCT_W'($urandom);
                light = PCT_W'($urandom);
                alpha = PCT_W'($urandom);
            end
            send_color(hue, sat, light, alpha);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_ramp_edges();
        test_out_of_range();
        test_random();
        s_tvalid <= 1'b0;
        // let the last input transfer reach the queue before draining
        @(posedge aclk);
        while (color_expect_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && color_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
